>>> rtl/core/audio_envelope_shaper_assert.svh
// Assertion macros for the envelope shaper core.
// Used by audio_envelope_shaper.sv; no other dependencies.
`ifndef AUDIO_ENVELOPE_SHAPER_ASSERT_SVH
`define AUDIO_ENVELOPE_SHAPER_ASSERT_SVH

// ante holds at a clock edge -> cons holds at the same edge
`define AES_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// ante holds at a clock edge -> cons holds at the following edge
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/aes_pkg.sv
// Shared types, constants and helper functions of the envelope shaper core.
// No dependencies; used by every module of the core.
`default_nettype none

package aes_pkg;

   // note timing
   localparam logic [15:0] SAMPLE_RATE  = 16'd32000;
   localparam logic [15:0] ATTACK_LEN   = 16'd6400;
   localparam logic [15:0] SUSTAIN_END  = 16'd24880;   // attack + sustain
   localparam logic [15:0] RELEASE_END  = 16'd31600;   // attack + sustain + release
   localparam logic [9:0]  ATTACK_STEP  = 10'd655;
   localparam logic [9:0]  RELEASE_STEP = 10'd624;

   // envelope phase codes
   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_ATTACK  = 2'd1;
   localparam logic [1:0] PH_SUSTAIN = 2'd2;
   localparam logic [1:0] PH_RELEASE = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_ATTACK_PEAK   = 2'd0;
   localparam logic [1:0] CSR_SUSTAIN_LEVEL = 2'd1;
   localparam logic [1:0] CSR_SUSTAIN_FLUCT = 2'd2;

   // bit-serial multiplier geometry
   localparam int MUL_A_W   = 21;
   localparam int MUL_B_W   = 11;
   localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
   localparam int MUL_CNT_W = 4;

   // bit-serial divider geometry: 3 doubling steps for the modulo, 11 quotient bits
   localparam int DIV_Q_W   = 11;
   localparam int DIV_STEPS = 14;
   localparam int DIV_CNT_W = 4;

   // attack curve, 33 points, 1024 = full scale
   localparam logic [10:0] CURVE [0:32] = '{
      11'd0,   11'd180, 11'd255, 11'd312, 11'd360, 11'd403, 11'd442, 11'd478, 11'd512,
      11'd544, 11'd574, 11'd603, 11'd630, 11'd656, 11'd681, 11'd705, 11'd728, 11'd750,
      11'd771, 11'd792, 11'd812, 11'd831, 11'd850, 11'd868, 11'd885, 11'd902, 11'd918,
      11'd933, 11'd949, 11'd963, 11'd977, 11'd991, 11'd1024};

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic        start;
      logic [15:0] rem;
   } div_req_type;

   function automatic logic [1:0] phase_of(input logic [15:0] pos);
      logic [1:0] ph;
      if (pos == 16'd0) begin
         ph = PH_IDLE;
      end else if (pos < ATTACK_LEN) begin
         ph = PH_ATTACK;
      end else if (pos < SUSTAIN_END) begin
         ph = PH_SUSTAIN;
      end else if (pos < RELEASE_END) begin
         ph = PH_RELEASE;
      end else begin
         ph = PH_IDLE;
      end
      return ph;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/audio_envelope_shaper.sv
// Top level of the attack / sustain / release envelope shaper.
// Depends on aes_pkg, aes_serial_mul, aes_serial_div and audio_envelope_shaper_assert.svh.
//
// Usage:
//  - req channel: one item per sample tick. req_tuser is the start flag (restart the
//    note at position one, level zero), req_tdata[11:0] the unsigned sample.
//  - rsp channel: one item per accepted req item. rsp_tdata[11:0] is bits 23..12 of
//    sample times envelope level, rsp_tuser is high while a note is running.
//  - csr channel: index 0 attack peak, 1 sustain level, 2 vibrato depth; always
//    ready, an unknown index is dropped. Write only while the block is idle.
//  - Timing: every product goes through one bit-serial multiplier; the vibrato angle
//    takes a 14-step serial divider. A new item can be accepted from the cycle after
//    the previous result is loaded, so items never overlap in the sequencer.
//  - Reset: registers return to attack peak 800, sustain level 850, depth 50; the
//    note is idle, level and held sample are zero.
//  - Stall: a finished result waits in the output register; if rsp_tready is low
//    when the next result is done, the sequencer holds and req_tready stays low.
`default_nettype none

module audio_envelope_shaper (
   input  wire logic        clock,
   input  wire logic        reset,
   // input stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [11:0] sample_in, [15:12] zero
   input  wire logic        req_tuser,   // [0] start_req
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [11:0] shaped_sample, [15:12] zero
   output logic             rsp_tuser,   // [0] out_valid
   // configuration writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [9:0]  csr_wdata
);

   // sequencer steps
   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_DISPATCH  = 4'd1;
   localparam logic [3:0] ST_ATK_POS   = 4'd2;
   localparam logic [3:0] ST_ATK_INT   = 4'd3;
   localparam logic [3:0] ST_ATK_PEAK  = 4'd4;
   localparam logic [3:0] ST_SUS_DIV   = 4'd5;
   localparam logic [3:0] ST_SUS_MAG   = 4'd6;
   localparam logic [3:0] ST_SUS_DEPTH = 4'd7;
   localparam logic [3:0] ST_REL_POS   = 4'd8;
   localparam logic [3:0] ST_REL_SQ    = 4'd9;
   localparam logic [3:0] ST_REL_LVL   = 4'd10;
   localparam logic [3:0] ST_OUT_MUL   = 4'd11;
   localparam logic [3:0] ST_DONE      = 4'd12;

   // configuration
   logic [9:0]  attack_peak_ff;
   logic [9:0]  sustain_level_ff;
   logic [5:0]  sustain_fluct_ff;

   // note state
   logic [15:0] position_ff;
   logic [1:0]  phase_ff;
   logic [9:0]  level_ff;
   logic [9:0]  level_in;
   logic [11:0] held_ff;

   // per-item work registers
   logic [3:0]  state_ff;
   logic [3:0]  state_in;
   logic        start_w_ff;
   logic [15:0] pos_w_ff;
   logic [1:0]  phase_w_ff;
   logic [10:0] cidx_ff;
   logic [10:0] cidx_in;
   logic        neg_ff;
   logic        neg_in;

   // result register
   logic        rsp_valid_ff;
   logic [11:0] rsp_shaped_ff;
   logic        rsp_flag_ff;

   // arithmetic units
   aes_pkg::mul_req_type             mul_req;
   aes_pkg::div_req_type             div_req;
   logic                             mul_done;
   logic [aes_pkg::MUL_P_W-1:0]      product;
   logic                             div_done;
   logic [aes_pkg::DIV_Q_W-1:0]      quotient;

   // combinational helpers
   logic        req_fire;
   logic        rsp_load;
   logic        issue_out;
   logic [15:0] pos_step;
   logic [15:0] pos_next;
   logic [4:0]  atk_idx;
   logic [5:0]  atk_nxt;
   logic [10:0] c_idx;
   logic [10:0] c_nxt;
   logic [10:0] c_diff;
   logic [10:0] interp;
   logic [9:0]  ang_x;
   logic [9:0]  mag;
   logic [16:0] depth_round;
   logic signed [11:0] sus_sum;
   logic [10:0] rel_norm;
   logic [10:0] rel_inv;
   logic [11:0] rel_v;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // advance the note position: wrap to idle after the sample rate
   assign pos_step = (position_ff == aes_pkg::SAMPLE_RATE) ? 16'd0 : position_ff + 16'd1;
   assign pos_next = req_tuser ? 16'd1 : ((position_ff == 16'd0) ? 16'd0 : pos_step);

   // attack curve interpolation operands
   assign atk_idx = product[21:17];
   assign atk_nxt = {1'b0, atk_idx} + 6'd1;
   assign c_idx   = aes_pkg::CURVE[{1'b0, atk_idx}];
   assign c_nxt   = aes_pkg::CURVE[atk_nxt];
   assign c_diff  = c_nxt - c_idx;
   assign interp  = cidx_ff + product[15:5];

   // vibrato: both halves of the turn use the low ten angle bits
   assign ang_x       = quotient[9:0];
   assign mag         = product[18:9];
   assign depth_round = {1'b0, product[15:0]} + 17'd255;
   assign sus_sum     = neg_ff
      ? $signed({2'b00, sustain_level_ff}) - $signed({3'b000, depth_round[16:8]})
      : $signed({2'b00, sustain_level_ff}) + $signed({4'b0000, product[15:8]});

   // release: clamp the normalised position, then square the remainder
   assign rel_norm = (product[22:12] > 11'd1024) ? 11'd1024 : product[22:12];
   assign rel_inv  = 11'd1024 - rel_norm;
   assign rel_v    = product[31:20];

   always_comb begin
      state_in  = state_ff;
      level_in  = level_ff;
      cidx_in   = cidx_ff;
      neg_in    = neg_ff;
      mul_req   = '0;
      div_req   = '0;
      issue_out = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (start_w_ff) begin
               level_in  = '0;
               issue_out = 1'b1;
            end else if (pos_w_ff == 16'd0) begin
               issue_out = 1'b1;   // idle note: hold the level
            end else begin
               case (phase_w_ff)
                  aes_pkg::PH_ATTACK: begin
                     mul_req.start = 1'b1;
                     mul_req.a     = aes_pkg::MUL_A_W'(pos_w_ff);
                     mul_req.b     = aes_pkg::MUL_B_W'(aes_pkg::ATTACK_STEP);
                     state_in      = ST_ATK_POS;
                  end
                  aes_pkg::PH_SUSTAIN: begin
                     div_req.start = 1'b1;
                     div_req.rem   = pos_w_ff - aes_pkg::ATTACK_LEN;
                     state_in      = ST_SUS_DIV;
                  end
                  aes_pkg::PH_RELEASE: begin
                     mul_req.start = 1'b1;
                     mul_req.a     = aes_pkg::MUL_A_W'(pos_w_ff - aes_pkg::SUSTAIN_END);
                     mul_req.b     = aes_pkg::MUL_B_W'(aes_pkg::RELEASE_STEP);
                     state_in      = ST_REL_POS;
                  end
                  default: begin
                     level_in  = '0;   // silence after the release
                     issue_out = 1'b1;
                  end
               endcase
            end
         end
         ST_ATK_POS: begin
            if (mul_done) begin
               cidx_in       = c_idx;
               mul_req.start = 1'b1;
               mul_req.a     = aes_pkg::MUL_A_W'(c_diff);
               mul_req.b     = aes_pkg::MUL_B_W'(product[16:12]);
               state_in      = ST_ATK_INT;
            end
         end
         ST_ATK_INT: begin
            if (mul_done) begin
               mul_req.start = 1'b1;
               mul_req.a     = aes_pkg::MUL_A_W'(interp);
               mul_req.b     = aes_pkg::MUL_B_W'(attack_peak_ff);
               state_in      = ST_ATK_PEAK;
            end
         end
         ST_ATK_PEAK: begin
            if (mul_done) begin
               level_in  = product[19:10];
               issue_out = 1'b1;
            end
         end
         ST_SUS_DIV: begin
            if (div_done) begin
               neg_in        = quotient[10];
               mul_req.start = 1'b1;
               mul_req.a     = aes_pkg::MUL_A_W'(11'd1024 - {1'b0, ang_x});
               mul_req.b     = aes_pkg::MUL_B_W'(ang_x);
               state_in      = ST_SUS_MAG;
            end
         end
         ST_SUS_MAG: begin
            if (mul_done) begin
               mul_req.start = 1'b1;
               mul_req.a     = aes_pkg::MUL_A_W'(mag);
               mul_req.b     = aes_pkg::MUL_B_W'(sustain_fluct_ff);
               state_in      = ST_SUS_DEPTH;
            end
         end
         ST_SUS_DEPTH: begin
            if (mul_done) begin
               if (sus_sum < 0) begin
                  level_in = '0;
               end else if (sus_sum > 12'sd1023) begin
                  level_in = 10'd1023;
               end else begin
                  level_in = sus_sum[9:0];
               end
               issue_out = 1'b1;
            end
         end
         ST_REL_POS: begin
            if (mul_done) begin
               mul_req.start = 1'b1;
               mul_req.a     = aes_pkg::MUL_A_W'(rel_inv);
               mul_req.b     = aes_pkg::MUL_B_W'(rel_inv);
               state_in      = ST_REL_SQ;
            end
         end
         ST_REL_SQ: begin
            if (mul_done) begin
               mul_req.start = 1'b1;
               mul_req.a     = product[aes_pkg::MUL_A_W-1:0];
               mul_req.b     = aes_pkg::MUL_B_W'(sustain_level_ff);
               state_in      = ST_REL_LVL;
            end
         end
         ST_REL_LVL: begin
            if (mul_done) begin
               level_in  = (rel_v > 12'd1023) ? 10'd1023 : rel_v[9:0];
               issue_out = 1'b1;
            end
         end
         ST_OUT_MUL: begin
            if (mul_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // final product: held sample times the new level
      if (issue_out) begin
         mul_req.start = 1'b1;
         mul_req.a     = aes_pkg::MUL_A_W'(held_ff);
         mul_req.b     = aes_pkg::MUL_B_W'(level_in);
         state_in      = ST_OUT_MUL;
      end
   end

   aes_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .req     (mul_req),
      .done    (mul_done),
      .product (product)
   );

   aes_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (quotient)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         attack_peak_ff   <= 10'd800;
         sustain_level_ff <= 10'd850;
         sustain_fluct_ff <= 6'd50;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            aes_pkg::CSR_ATTACK_PEAK:   attack_peak_ff   <= csr_wdata;
            aes_pkg::CSR_SUSTAIN_LEVEL: sustain_level_ff <= csr_wdata;
            aes_pkg::CSR_SUSTAIN_FLUCT: sustain_fluct_ff <= csr_wdata[5:0];
            default: begin
               // drop writes to unknown indexes
            end
         endcase
      end
   end

   // note state and sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         position_ff <= '0;
         phase_ff    <= aes_pkg::PH_IDLE;
         level_ff    <= '0;
         held_ff     <= '0;
         neg_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
         neg_ff   <= neg_in;
         if (req_fire) begin
            // level work uses the old position; the new one is stored at once
            position_ff <= pos_next;
            phase_ff    <= aes_pkg::phase_of(pos_next);
            held_ff     <= req_tdata[11:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      cidx_ff <= cidx_in;
      if (req_fire) begin
         start_w_ff <= req_tuser;
         pos_w_ff   <= position_ff;
         phase_w_ff <= phase_ff;
      end
   end

   // result register: holds a finished item while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_shaped_ff <= product[23:12];
         rsp_flag_ff   <= (position_ff != 16'd0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_shaped_ff};
   assign rsp_tuser  = rsp_flag_ff;

`include "audio_envelope_shaper_assert.svh"

   `AES_ASSERT_NEXT(a_accept_dispatch, clock, reset, req_fire, state_ff == ST_DISPATCH, "accepted item did not reach dispatch")
   `AES_ASSERT_SAME(a_div_owner, clock, reset, div_done, state_ff == ST_SUS_DIV, "divider finished outside the vibrato step")
   `AES_ASSERT_SAME(a_mul_owner, clock, reset, mul_done, state_ff != ST_IDLE && state_ff != ST_DISPATCH && state_ff != ST_SUS_DIV && state_ff != ST_DONE, "multiplier finished with no step waiting")
   `AES_ASSERT_SAME(a_idle_phase, clock, reset, position_ff == 16'd0, phase_ff == aes_pkg::PH_IDLE, "idle note with a live phase")

endmodule

`default_nettype wire

>>> rtl/core/aes_serial_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle, LSB first.
// Depends on aes_pkg for operand widths and the request struct.
`default_nettype none

module aes_serial_mul (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire aes_pkg::mul_req_type          req,
   output logic                               done,
   output logic [aes_pkg::MUL_P_W-1:0]        product
);

   localparam logic [aes_pkg::MUL_CNT_W-1:0] LAST_STEP =
      aes_pkg::MUL_CNT_W'(aes_pkg::MUL_B_W - 1);

   logic                              busy_ff;
   logic                              done_ff;
   logic [aes_pkg::MUL_CNT_W-1:0]     cnt_ff;
   logic [aes_pkg::MUL_A_W-1:0]       a_ff;
   logic [aes_pkg::MUL_A_W-1:0]       acc_ff;
   logic [aes_pkg::MUL_B_W-1:0]       bq_ff;
   logic [aes_pkg::MUL_A_W:0]         sum;

   // add the multiplicand when the current multiplier bit is set
   assign sum = {1'b0, acc_ff} + (bq_ff[0] ? {1'b0, a_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // shift the partial sum right; low product bits fill the multiplier register
   always_ff @(posedge clock) begin
      if (req.start) begin
         a_ff   <= req.a;
         acc_ff <= '0;
         bq_ff  <= req.b;
      end else if (busy_ff) begin
         acc_ff <= sum[aes_pkg::MUL_A_W:1];
         bq_ff  <= {sum[0], bq_ff[aes_pkg::MUL_B_W-1:1]};
      end
   end

   assign done    = done_ff;
   assign product = {acc_ff, bq_ff};

endmodule

`default_nettype wire

>>> rtl/core/aes_serial_div.sv
// Restoring divider by the sample rate, one remainder doubling per cycle.
// Depends on aes_pkg for the divisor, step count and request struct.
`default_nettype none

module aes_serial_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire aes_pkg::div_req_type          req,
   output logic                               done,
   output logic [aes_pkg::DIV_Q_W-1:0]        quotient
);

   localparam logic [aes_pkg::DIV_CNT_W-1:0] LAST_STEP =
      aes_pkg::DIV_CNT_W'(aes_pkg::DIV_STEPS - 1);

   logic                              busy_ff;
   logic                              done_ff;
   logic [aes_pkg::DIV_CNT_W-1:0]     cnt_ff;
   logic [15:0]                       rem_ff;
   logic [aes_pkg::DIV_Q_W-1:0]       quot_ff;
   logic [16:0]                       twice;
   logic [16:0]                       diff;
   logic                              ge;

   assign twice = {rem_ff, 1'b0};
   assign ge    = twice >= {1'b0, aes_pkg::SAMPLE_RATE};
   assign diff  = twice - {1'b0, aes_pkg::SAMPLE_RATE};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // early quotient bits drop off the top: they only reduce modulo the rate
   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff  <= req.rem;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= ge ? diff[15:0] : twice[15:0];
         quot_ff <= {quot_ff[aes_pkg::DIV_Q_W-2:0], ge};
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire
